@@ rtl/core/gwcs_pkg.sv @@
// shared types and constants of the gaussian weighted color sample block
package gwcs_pkg;

  // field and register widths
  localparam int CHAN_W      = 8;
  localparam int KSIZE_W     = 4;
  localparam int WEIGHT_W    = 17;
  localparam int NUM_WEIGHTS = 7;
  localparam int ACC_W       = 50;
  localparam int WIDX_W      = $clog2(NUM_WEIGHTS);

  // apb register map
  localparam int APB_DATA_W = 32;
  localparam int NUM_REGS   = NUM_WEIGHTS + 1;
  localparam int APB_ADDR_W = $clog2(NUM_REGS) + 2;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);

  localparam logic [REG_IDX_W-1:0] RegKernelSize = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] RegWeightD0   = REG_IDX_W'(1);

  // register reset values
  localparam logic [KSIZE_W-1:0] KernelSizeRst = KSIZE_W'(3);
  localparam logic [WEIGHT_W-1:0] WeightD0Rst  = WEIGHT_W'(29610);
  localparam logic [WEIGHT_W-1:0] WeightD1Rst  = WEIGHT_W'(17963);

  // scaled accumulator value at and above which the average saturates
  localparam int SatLimit = 255 * 256;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weights_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // take a pixel, form the pair weight, step the position
    logic mul_alpha;  // pair weight times opacity
    logic mul_chan;   // weighted opacity times each channel
    logic accum;      // saturating add into the accumulators
    logic emit;       // scale accumulators into the output register and clear
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;      // pixel in flight closes the window
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

@@ rtl/core/gwcs_if.sv @@
// pixel and result channel interfaces

// pixel request channel
interface gwcs_pix_if import gwcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_blue;
  logic [CHAN_W-1:0] chan_green;
  logic [CHAN_W-1:0] chan_red;
  logic [CHAN_W-1:0] opacity;

  modport source (output valid, chan_blue, chan_green, chan_red, opacity, input ready);
  modport sink (input valid, chan_blue, chan_green, chan_red, opacity, output ready);
endinterface

// averaged color result channel
interface gwcs_res_if import gwcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] avg_blue;
  logic [CHAN_W-1:0] avg_green;
  logic [CHAN_W-1:0] avg_red;

  modport source (output valid, avg_blue, avg_green, avg_red, input ready);
  modport sink (input valid, avg_blue, avg_green, avg_red, output ready);
endinterface

@@ rtl/core/gwcs_ctrl.sv @@
// sequencing state machine of the gaussian weighted color sample block
module gwcs_ctrl import gwcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StAlpha = 5'b00010,
    StChan  = 5'b00100,
    StAccum = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StAlpha;
        end
      end
      StAlpha: begin
        cmd_o.mul_alpha = 1'b1;
        state_d         = StChan;
      end
      StChan: begin
        cmd_o.mul_chan = 1'b1;
        state_d        = StAccum;
      end
      StAccum: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.last ? StEmit : StIdle;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/gwcs_datapath.sv @@
// weighting multipliers, accumulators, window position and output register
module gwcs_datapath import gwcs_pkg::*; #(
  parameter int MAX_KERNEL       = 13,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [KSIZE_W-1:0] kernel_size_i,
  input  weights_t           weights_i,
  input  logic [CHAN_W-1:0]  chan_blue_i,
  input  logic [CHAN_W-1:0]  chan_green_i,
  input  logic [CHAN_W-1:0]  chan_red_i,
  input  logic [CHAN_W-1:0]  opacity_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic [CHAN_W-1:0]  avg_blue_o,
  output logic [CHAN_W-1:0]  avg_green_o,
  output logic [CHAN_W-1:0]  avg_red_o
);

  localparam int ProdW = 2 * WEIGHT_W;
  localparam int PwW   = ProdW - WEIGHT_FRAC_BITS;
  localparam int FW    = PwW + CHAN_W;
  localparam int TermW = FW + CHAN_W;
  localparam int Cap   = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
  localparam int CapW  = $clog2(Cap + 1) > KSIZE_W ? $clog2(Cap + 1) : KSIZE_W;
  localparam logic [ACC_W-1:0] AccMax = '1;

  // odd window side and its centre
  logic [KSIZE_W-1:0] side;
  logic [CapW-1:0]    side_ext;
  logic [KSIZE_W-1:0] centre;

  always_comb begin
    side = kernel_size_i;
    if (!side[0]) begin
      side = (side == '0) ? KSIZE_W'(1) : side - KSIZE_W'(1);
    end
    side_ext = CapW'(side);
    if (side_ext > CapW'(Cap)) begin
      side_ext = CapW'(Cap);
    end
    centre = side_ext[KSIZE_W-1:0] >> 1;
  end

  // weight picked by distance from the centre
  function automatic logic [WEIGHT_W-1:0] weight_at(
    input logic [KSIZE_W-1:0] pos,
    input logic [KSIZE_W-1:0] mid,
    input weights_t           w
  );
    logic [KSIZE_W-1:0] span;
    span = (pos >= mid) ? pos - mid : mid - pos;
    if (span < KSIZE_W'(NUM_WEIGHTS)) begin
      return w[span[WIDX_W-1:0]];
    end
    return '0;
  endfunction

  // floor(acc / (255 << frac bits)) saturated at 255
  function automatic logic [CHAN_W-1:0] scale_out(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] x;
    logic [15:0]      xl;
    logic [24:0]      xm;
    logic [8:0]       q0;
    logic [16:0]      qm;
    logic [16:0]      rem;
    x  = acc >> WEIGHT_FRAC_BITS;
    xl = x[15:0];
    // reciprocal of 255 as 257 / 2^16, at most one low
    xm  = {1'b0, xl, 8'b0} + 25'(xl);
    q0  = xm[24:16];
    qm  = {q0, 8'b0} - 17'(q0);
    rem = 17'(xl) - qm;
    if (x >= ACC_W'(SatLimit)) begin
      return '1;
    end
    if (rem >= 17'd255) begin
      q0 = q0 + 9'd1;
    end
    return q0[CHAN_W-1:0];
  endfunction

  logic [KSIZE_W-1:0] row_q, row_d, col_q, col_d;
  logic               last_q, last_d;
  logic [PwW-1:0]     pw_q;
  logic [ProdW-1:0]   wprod;
  logic [CHAN_W-1:0]  blue_q, green_q, red_q, alpha_q;
  logic [FW-1:0]      f_q;
  logic [TermW-1:0]   term_b_q, term_g_q, term_r_q;
  logic [ACC_W-1:0]   acc_b_q, acc_g_q, acc_r_q;
  logic [ACC_W-1:0]   acc_b_d, acc_g_d, acc_r_d;
  logic               out_valid_q;
  logic [CHAN_W-1:0]  avg_b_q, avg_g_q, avg_r_q;

  assign wprod = ProdW'(weight_at(row_q, centre, weights_i))
               * ProdW'(weight_at(col_q, centre, weights_i));

  // raster position inside the window
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    last_d = 1'b0;
    if ({1'b0, col_q} + 5'd1 < {1'b0, side_ext[KSIZE_W-1:0]}) begin
      col_d = col_q + KSIZE_W'(1);
    end else begin
      col_d = '0;
      if ({1'b0, row_q} + 5'd1 < {1'b0, side_ext[KSIZE_W-1:0]}) begin
        row_d = row_q + KSIZE_W'(1);
      end else begin
        row_d  = '0;
        last_d = 1'b1;
      end
    end
  end

  // saturating accumulate
  function automatic logic [ACC_W-1:0] sat_add(
    input logic [ACC_W-1:0] acc,
    input logic [TermW-1:0] term
  );
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + (ACC_W + 1)'(term);
    return sum[ACC_W] ? AccMax : sum[ACC_W-1:0];
  endfunction

  always_comb begin
    acc_b_d = acc_b_q;
    acc_g_d = acc_g_q;
    acc_r_d = acc_r_q;
    priority if (cmd_i.emit) begin
      acc_b_d = '0;
      acc_g_d = '0;
      acc_r_d = '0;
    end else if (cmd_i.accum) begin
      acc_b_d = sat_add(acc_b_q, term_b_q);
      acc_g_d = sat_add(acc_g_q, term_g_q);
      acc_r_d = sat_add(acc_r_q, term_r_q);
    end
  end

  // control state: position, accumulators, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      last_q      <= 1'b0;
      acc_b_q     <= '0;
      acc_g_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        row_q  <= row_d;
        col_q  <= col_d;
        last_q <= last_d;
      end
      acc_b_q <= acc_b_d;
      acc_g_q <= acc_g_d;
      acc_r_q <= acc_r_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // multiply pipeline and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pw_q    <= wprod[ProdW-1:WEIGHT_FRAC_BITS];
      blue_q  <= chan_blue_i;
      green_q <= chan_green_i;
      red_q   <= chan_red_i;
      alpha_q <= opacity_i;
    end
    if (cmd_i.mul_alpha) begin
      f_q <= FW'(pw_q) * FW'(alpha_q);
    end
    if (cmd_i.mul_chan) begin
      term_b_q <= TermW'(f_q) * TermW'(blue_q);
      term_g_q <= TermW'(f_q) * TermW'(green_q);
      term_r_q <= TermW'(f_q) * TermW'(red_q);
    end
    if (cmd_i.emit) begin
      avg_b_q <= scale_out(acc_b_q);
      avg_g_q <= scale_out(acc_g_q);
      avg_r_q <= scale_out(acc_r_q);
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || res_ready_i;
  assign res_valid_o    = out_valid_q;
  assign avg_blue_o     = avg_b_q;
  assign avg_green_o    = avg_g_q;
  assign avg_red_o      = avg_r_q;

endmodule

@@ rtl/core/gaussian_weighted_color_sample_top.sv @@
// top level: apb register file, controller and datapath of the color sampler
//
// Takes the pixels of one square window in raster order and returns one
// Gaussian-weighted color average per window, each channel weighted by
// w[row distance] * w[column distance] * opacity / 255 and saturated at 255.
// Each pixel request occupies the block while the controller steps through
// accept, opacity multiply, channel multiply and accumulate on the single
// shared multiply chain; the last pixel of a window then adds a step that
// scales the accumulators into the output register once that register is
// free. A pending result does not hold off the next pixel. Registers
// (kernel_size at 0x00, weight_d0..weight_d6 at 0x04..0x1c) must be
// written over APB only while no pixel is in flight; the block itself
// does not enforce this.
module gaussian_weighted_color_sample_top import gwcs_pkg::*; #(
  parameter int MAX_KERNEL       = 13,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gwcs_pix_if.sink              pix_i,
  gwcs_res_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [KSIZE_W-1:0]   kernel_size_q;
  weights_t             weights_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  cmd_t                 cmd;
  sts_t                 sts;

  // apb register decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q <= KernelSizeRst;
      weights_q     <= weights_t'({WeightD1Rst, WeightD0Rst});
    end else if (reg_wr) begin
      if (reg_idx == RegKernelSize) begin
        kernel_size_q <= pwdata[KSIZE_W-1:0];
      end else begin
        weights_q[WIDX_W'(reg_idx - RegWeightD0)] <= pwdata[WEIGHT_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (reg_idx == RegKernelSize) begin
      prdata = APB_DATA_W'(kernel_size_q);
    end else begin
      prdata = APB_DATA_W'(weights_q[WIDX_W'(reg_idx - RegWeightD0)]);
    end
  end

  gwcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gwcs_datapath #(
    .MAX_KERNEL       (MAX_KERNEL),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kernel_size_i (kernel_size_q),
    .weights_i     (weights_q),
    .chan_blue_i   (pix_i.chan_blue),
    .chan_green_i  (pix_i.chan_green),
    .chan_red_i    (pix_i.chan_red),
    .opacity_i     (pix_i.opacity),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .avg_blue_o    (res_o.avg_blue),
    .avg_green_o   (res_o.avg_green),
    .avg_red_o     (res_o.avg_red)
  );

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!res_o.valid || res_o.ready))
    else $error("result written over a pending result");

  // controller issues at most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("overlapping datapath commands");

  // an accepted pixel blocks the next one until its work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel accepted while previous one in flight");

  // a window result is never emitted while the controller is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !pix_i.ready)
    else $error("result emitted while idle");

endmodule

@@ test/tb_top.sv @@
// testbench for the gaussian weighted color sampler: directed table, random windows, predictor
module tb_top import gwcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX        = 13;
  localparam int WFRAC       = 16;
  localparam int SIDE_CAP    = (KMAX % 2 == 1) ? KMAX : KMAX - 1;
  localparam int ITEM_TARGET = 1250;
  localparam int SETTLE      = 20;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned ACC_TOP = (64'd1 << ACC_W) - 64'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } color_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct {
    row_kind_e                 kind;
    logic [REG_IDX_W-1:0]      idx;
    logic [APB_DATA_W-1:0]     value;
    pixel_t                    pix;
    bit                        typed;
    color_t                    want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gwcs_pix_if pix_if ();
  gwcs_res_if res_if ();

  gaussian_weighted_color_sample_top #(
    .MAX_KERNEL      (KMAX),
    .WEIGHT_FRAC_BITS(WFRAC)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // mirrored registers and window state
  logic [KSIZE_W-1:0]  cfg_ksize;
  logic [WEIGHT_W-1:0] cfg_wt [NUM_WEIGHTS];
  logic [ACC_W-1:0]    sum_b, sum_g, sum_r;
  int unsigned         row_at, col_at;

  color_t      avg_q [$];
  plan_row_t   plan [$];
  int unsigned pixels_sent, averages_seen, writes_done, mismatches, widest;
  int unsigned cycles;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_asked, hold_given, hold_left;
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // window side after the odd and cap rules
  function automatic int unsigned side_in_force();
    int unsigned n;
    n = cfg_ksize;
    if (n % 2 == 0) n = (n == 0) ? 1 : n - 1;
    if (n > SIDE_CAP) n = SIDE_CAP;
    return n;
  endfunction

  function automatic longint unsigned weight_for(input int unsigned pos, input int unsigned mid);
    int unsigned d;
    d = (pos >= mid) ? pos - mid : mid - pos;
    return (d < NUM_WEIGHTS) ? 64'(cfg_wt[d]) : 64'd0;
  endfunction

  function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] acc,
                                                   input longint unsigned term);
    longint unsigned s;
    s = 64'(acc) + term;
    return (s > ACC_TOP) ? ACC_W'(ACC_TOP) : ACC_W'(s);
  endfunction

  function automatic logic [CHAN_W-1:0] to_average(input logic [ACC_W-1:0] acc);
    longint unsigned q;
    q = 64'(acc) / (64'd255 << WFRAC);
    return (q > 255) ? CHAN_W'(255) : CHAN_W'(q);
  endfunction

  // accumulate one pixel, close the window at its last position
  task automatic weigh_pixel(input pixel_t p, output bit closes, output color_t avg);
    int unsigned     n, mid;
    longint unsigned pair, f;
    n   = side_in_force();
    mid = n / 2;
    if (n > widest) widest = n;
    pair  = (weight_for(row_at, mid) * weight_for(col_at, mid)) >> WFRAC;
    f     = pair * 64'(p.alpha);
    sum_b = add_clamped(sum_b, f * 64'(p.blue));
    sum_g = add_clamped(sum_g, f * 64'(p.green));
    sum_r = add_clamped(sum_r, f * 64'(p.red));
    closes = 1'b0;
    avg    = '0;
    if (col_at + 1 < n) begin
      col_at++;
    end else begin
      col_at = 0;
      if (row_at + 1 < n) begin
        row_at++;
      end else begin
        closes    = 1'b1;
        avg.blue  = to_average(sum_b);
        avg.green = to_average(sum_g);
        avg.red   = to_average(sum_r);
        sum_b     = '0;
        sum_g     = '0;
        sum_r     = '0;
        row_at    = 0;
      end
    end
  endtask

  // apb write, mirrored once the access phase completes
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (pready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    if (idx == RegKernelSize) cfg_ksize = value[KSIZE_W-1:0];
    else cfg_wt[idx - RegWeightD0] = value[WEIGHT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    writes_done++;
    // leave the bus idle between transfers
    @(posedge clk_i);
  endtask

  // offer one pixel request in bursts, predict once accepted
  task automatic push_pixel(input pixel_t p, input bit typed, input color_t want);
    bit          closes;
    color_t      avg;
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    pix_if.valid      <= 1'b1;
    pix_if.chan_blue  <= p.blue;
    pix_if.chan_green <= p.green;
    pix_if.chan_red   <= p.red;
    pix_if.opacity    <= p.alpha;
    forever begin
      @(negedge clk_i);
      if (pix_if.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    weigh_pixel(p, closes, avg);
    pixels_sent++;
    if (closes) avg_q.push_back(typed ? want : avg);
  endtask

  // stop offering, wait for every average, then let the pipeline empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (avg_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.blue  = random_chan();
    p.green = random_chan();
    p.red   = random_chan();
    case ($urandom_range(0, 7))
      0, 1:    p.alpha = '1;
      2:       p.alpha = '0;
      default: p.alpha = CHAN_W'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  // mostly small windows, now and then the largest ones
  function automatic logic [APB_DATA_W-1:0] pick_kernel();
    case ($urandom_range(0, 9))
      7:       return APB_DATA_W'($urandom_range(6, 11));
      8, 9:    return APB_DATA_W'($urandom_range(12, 15));
      default: return APB_DATA_W'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return APB_DATA_W'(65536);
      2:       return APB_DATA_W'({WEIGHT_W{1'b1}});
      default: return APB_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic plan_row_t px(input int b, input int g, input int r, input int a);
    plan_row_t row;
    row.kind  = ROW_PIXEL;
    row.idx   = '0;
    row.value = '0;
    row.pix   = '{CHAN_W'(b), CHAN_W'(g), CHAN_W'(r), CHAN_W'(a)};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t pxe(input int b, input int g, input int r, input int a,
                                    input int eb, input int eg, input int er);
    plan_row_t row;
    row       = px(b, g, r, a);
    row.typed = 1'b1;
    row.want  = '{CHAN_W'(eb), CHAN_W'(eg), CHAN_W'(er)};
    return row;
  endfunction

  function automatic plan_row_t wr(input logic [REG_IDX_W-1:0] idx, input int value);
    plan_row_t row;
    row       = px(0, 0, 0, 0);
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = APB_DATA_W'(value);
    return row;
  endfunction

  task automatic flag_result(input string why, input color_t want, input color_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %0d/%0d/%0d got %0d/%0d/%0d", $time, why,
               want.blue, want.green, want.red, got.blue, got.green, got.red);
  endtask

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_asked != hold_given) begin
        hold_given++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(16, 160);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   res_if.ready <= 1'b1;
          RX_HALF:   res_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:   res_if.ready <= ~res_if.ready;
        endcase
      end
    end
  end

  // result check: handshake seen at the falling edge completes at the next rising edge
  always @(negedge clk_i) begin
    color_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.avg_blue, res_if.avg_green, res_if.avg_red};
      averages_seen++;
      if (avg_q.size() == 0) begin
        flag_result("average with none pending", '0, got);
      end else begin
        want = avg_q.pop_front();
        if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red)
          flag_result("average mismatch", want, got);
      end
    end
  end

  // stimulus
  initial begin
    int          phase;
    int unsigned side, per, count;
    pix_if.valid      = 1'b0;
    pix_if.chan_blue  = '0;
    pix_if.chan_green = '0;
    pix_if.chan_red   = '0;
    pix_if.opacity    = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_ni            = 1'b0;

    cfg_ksize = KernelSizeRst;
    foreach (cfg_wt[d]) cfg_wt[d] = '0;
    cfg_wt[0] = WeightD0Rst;
    cfg_wt[1] = WeightD1Rst;
    sum_b     = '0;
    sum_g     = '0;
    sum_r     = '0;
    row_at    = 0;
    col_at    = 0;

    // one window with reset registers
    plan.push_back(px(255, 255, 255, 255));
    plan.push_back(px(0, 0, 0, 0));
    plan.push_back(px(255, 0, 255, 0));
    plan.push_back(px(0, 255, 0, 255));
    plan.push_back(px(255, 255, 255, 255));
    plan.push_back(px(170, 85, 170, 85));
    plan.push_back(px(85, 170, 85, 170));
    plan.push_back(px(1, 128, 254, 127));
    plan.push_back(px(255, 255, 255, 255));
    // zero size acts as one, unit weight passes channels through
    plan.push_back(wr(RegKernelSize, 0));
    plan.push_back(wr(RegWeightD0, 65536));
    plan.push_back(pxe(255, 255, 255, 255, 255, 255, 255));
    plan.push_back(pxe(0, 0, 0, 255, 0, 0, 0));
    plan.push_back(pxe(255, 255, 255, 0, 0, 0, 0));
    plan.push_back(pxe(200, 100, 1, 255, 200, 100, 1));
    plan.push_back(wr(RegWeightD0, 0));
    plan.push_back(pxe(255, 255, 255, 255, 0, 0, 0));
    // even size two acts as one, half weight squared is a quarter
    plan.push_back(wr(RegKernelSize, 2));
    plan.push_back(wr(RegWeightD0, 32768));
    plan.push_back(pxe(255, 128, 7, 255, 63, 32, 1));
    // saturated output, then shrink mid-window so the last pixel sits too far out
    plan.push_back(wr(RegKernelSize, 9));
    for (int d = 0; d < NUM_WEIGHTS; d++)
      plan.push_back(wr(RegWeightD0 + REG_IDX_W'(d), 65536));
    plan.push_back(px(255, 0, 0, 255));
    plan.push_back(px(255, 0, 0, 255));
    repeat (5) plan.push_back(px(0, 0, 255, 0));
    plan.push_back(wr(RegKernelSize, 1));
    plan.push_back(pxe(0, 255, 0, 255, 255, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    gaps_on = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        push_pixel(plan[i].pix, plan[i].typed, plan[i].want);
      end
    end

    // random phases, registers rewritten only once the block has drained
    for (phase = 0; pixels_sent < ITEM_TARGET; phase++) begin
      settle();
      if (phase == 1) begin
        reg_write(RegKernelSize, 1);
      end else begin
        if (phase == 0 || $urandom_range(0, 2) == 0) reg_write(RegKernelSize, pick_kernel());
        for (int d = 0; d < NUM_WEIGHTS; d++)
          if (phase == 0 || $urandom_range(0, 2) == 0)
            reg_write(RegWeightD0 + REG_IDX_W'(d), pick_weight());
      end
      side    = side_in_force();
      per     = side * side;
      count   = (side <= 5) ? per * $urandom_range(1, 6) : per;
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, per);
      gaps_on = ($urandom_range(0, 3) != 0);
      // one-pixel windows against a long receiver hold-off fill the block
      if (phase == 1) begin
        hold_asked++;
        count   = 40;
        gaps_on = 1'b0;
      end
      repeat (count) push_pixel(random_pixel(), 1'b0, '0);
    end

    settle();
    $display("covered %0d pixels, %0d window averages, %0d register writes, sides up to %0d",
             pixels_sent, averages_seen, writes_done, widest);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d bad averages", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
